/* hdl/eor_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eor_pkg: shared definitions of the ellipse outline rasterizer
// Field widths, datapath operation codes, controller/datapath link types and
// the quarter-unit truncation used for the decision values.
// ----------------------------------------------------------------------------
package eor_pkg;

	localparam int COORD_BITS = 10;             // significant bits of a corner
	localparam int CORNER_W   = 10;             // width of a corner field
	localparam int COLOR_W    = 8;
	localparam int SEMI_W     = COORD_BITS - 1; // semi-axis
	localparam int SQ_W       = 2 * SEMI_W;     // squared semi-axis
	localparam int OFS_W      = 12;             // signed point offsets
	localparam int PT_W       = 12;             // output coordinates
	localparam int GRAD_W     = 32;
	localparam int DEC_W      = 48;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = SQ_W + 1;
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 56;

	// Input command kinds carried in tuser.
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	// Datapath operations.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL_AA  = 4'd2;
	localparam logic [OP_W-1:0] OP_MUL_BB  = 4'd3;
	localparam logic [OP_W-1:0] OP_MUL_AAB = 4'd4;
	localparam logic [OP_W-1:0] OP_INIT    = 4'd5;
	localparam logic [OP_W-1:0] OP_STEP    = 4'd6;
	localparam logic [OP_W-1:0] OP_DECIDE  = 4'd7;
	localparam logic [OP_W-1:0] OP_RC1     = 4'd8;
	localparam logic [OP_W-1:0] OP_RC2     = 4'd9;
	localparam logic [OP_W-1:0] OP_RC3     = 4'd10;
	localparam logic [OP_W-1:0] OP_RC4     = 4'd11;
	localparam logic [OP_W-1:0] OP_RC5     = 4'd12;
	localparam logic [OP_W-1:0] OP_RC6     = 4'd13;
	localparam logic [OP_W-1:0] OP_RC7     = 4'd14;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            region_two;
		logic            load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic gx_lt_gy;
		logic oy_neg;
	} dp_sts_t;

	// Divide by four, rounding toward zero.
	function automatic logic signed [DEC_W-1:0] quarter_trunc(
		input logic signed [DEC_W-1:0] q
	);
		logic signed [DEC_W-1:0] adj;
		adj = q[DEC_W-1] ? (q + DEC_W'(3)) : q;
		return adj >>> 2;
	endfunction

endpackage
`default_nettype wire

/* hdl/ellipse_outline_rasterizer.sv */
`default_nettype none
// An advance transfer runs the step, the decision update and the end check, then loads its
// result once the output register is free; a step that ends region one first forms the
// region two decision. The input takes no new transfer until the result is loaded.
// A start busies the input for three multiplies; a zero semi-axis adds the region change.
// arst_n clears the sequencer, the phase and the output valid; no ellipse is active after it.
// ----------------------------------------------------------------------------
// ellipse_outline_rasterizer: midpoint ellipse outline generator
// Latches an ellipse from two corners on a start transfer and returns one
// step of four mirrored points per advance transfer, tlast on the final step.
// ----------------------------------------------------------------------------
module ellipse_outline_rasterizer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// corner_ax, corner_ay, corner_bx, corner_by, pen_color
	input  wire logic [eor_pkg::S_DATA_W-1:0]  s_tdata,
	// command
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// right_x, left_x, lower_y, upper_y, color_out
	output logic [eor_pkg::M_DATA_W-1:0]       m_tdata,
	output logic                               m_tlast
);
	import eor_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	eor_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

	eor_datapath u_dp (
		.clk     (clk),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata)
	);

`ifndef SYNTH
	// The output register is only reloaded once its previous result has gone.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("output register reloaded while holding a result");

	// Every step is followed by its decision update.
	a_step_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_STEP) |=> (cmd.op == OP_DECIDE))
		else $error("step not followed by decision update");

	// A start occupies the block while the axes are squared.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == CMD_START) |=> (!s_tready && cmd.op == OP_MUL_AA))
		else $error("start did not enter the setup sequence");
`endif

endmodule
`default_nettype wire

/* hdl/eor_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eor_datapath: arithmetic of the ellipse outline rasterizer
// Holds the ellipse state, one shared registered multiplier, the decision
// accumulator and the output data register. Driven by operation codes.
// ----------------------------------------------------------------------------
module eor_datapath (
	input  wire logic                          clk,
	input  wire logic [eor_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire eor_pkg::ctrl_cmd_t            cmd,
	output eor_pkg::dp_sts_t                   sts,
	output logic [eor_pkg::M_DATA_W-1:0]       m_tdata
);
	import eor_pkg::*;

	logic [COORD_BITS-1:0]     ax, ay, bx, by;
	logic [COORD_BITS:0]       sum_x, sum_y;
	logic [COORD_BITS-1:0]     dif_x, dif_y;
	logic [SEMI_W-1:0]         a_new, b_new;

	logic [COORD_BITS-1:0]     center_x_q, center_y_q;
	logic [SEMI_W-1:0]         semi_a_q, semi_b_q;
	logic [SQ_W-1:0]           sq_a_q, sq_b_q;
	logic signed [OFS_W-1:0]   ofs_x_q, ofs_y_q;
	logic signed [GRAD_W-1:0]  grad_x_q, grad_y_q;
	logic signed [DEC_W-1:0]   dec_q, acc_q, prod_q;
	logic [COLOR_W-1:0]        color_q;
	logic                      br_q;
	logic [PT_W-1:0]           pt_rx_q, pt_lx_q, pt_ly_q, pt_uy_q;
	logic [M_DATA_W-1:0]       out_q;

	logic signed [MUL_A_W-1:0]         mul_a;
	logic signed [MUL_B_W-1:0]         mul_b;
	logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
	logic signed [MUL_B_W-1:0]         tx, ym;
	logic signed [DEC_W-1:0]           gx_w, gy_w, sqa_w, sqb_w, init_sum;
	logic signed [GRAD_W-1:0]          two_sqa, two_sqb;
	logic                              dec_neg, dec_pos;

	assign ax = s_tdata[COORD_BITS-1:0];
	assign ay = s_tdata[CORNER_W+COORD_BITS-1:CORNER_W];
	assign bx = s_tdata[2*CORNER_W+COORD_BITS-1:2*CORNER_W];
	assign by = s_tdata[3*CORNER_W+COORD_BITS-1:3*CORNER_W];

	assign sum_x = {1'b0, ax} + {1'b0, bx};
	assign sum_y = {1'b0, ay} + {1'b0, by};
	assign dif_x = (bx > ax) ? (bx - ax) : (ax - bx);
	assign dif_y = (by > ay) ? (by - ay) : (ay - by);
	assign a_new = dif_x[COORD_BITS-1:1];
	assign b_new = dif_y[COORD_BITS-1:1];

	assign tx = {{(MUL_B_W-OFS_W-1){ofs_x_q[OFS_W-1]}}, ofs_x_q, 1'b1};
	assign ym = MUL_B_W'(ofs_y_q) - MUL_B_W'(1);

	assign gx_w  = DEC_W'(grad_x_q);
	assign gy_w  = DEC_W'(grad_y_q);
	assign sqa_w = DEC_W'(sq_a_q);
	assign sqb_w = DEC_W'(sq_b_q);
	assign two_sqa = GRAD_W'({sq_a_q, 1'b0});
	assign two_sqb = GRAD_W'({sq_b_q, 1'b0});
	assign init_sum = (sqb_w <<< 2) - (prod_q <<< 2) + sqa_w;

	assign dec_neg = dec_q[DEC_W-1];
	assign dec_pos = !dec_q[DEC_W-1] && (|dec_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_AA: begin
				mul_a = MUL_A_W'(semi_a_q);
				mul_b = MUL_B_W'(semi_a_q);
			end
			OP_MUL_BB: begin
				mul_a = MUL_A_W'(semi_b_q);
				mul_b = MUL_B_W'(semi_b_q);
			end
			OP_MUL_AAB: begin
				mul_a = MUL_A_W'(sq_a_q);
				mul_b = MUL_B_W'(semi_b_q);
			end
			OP_RC1: begin
				mul_a = MUL_A_W'(sq_b_q);
				mul_b = tx;
			end
			OP_RC2: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = tx;
			end
			OP_RC3: begin
				mul_a = MUL_A_W'(sq_a_q);
				mul_b = ym;
			end
			OP_RC4: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = ym;
			end
			OP_RC5: begin
				mul_a = MUL_A_W'(sq_a_q);
				mul_b = MUL_B_W'(sq_b_q);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				center_x_q <= sum_x[COORD_BITS:1];
				center_y_q <= sum_y[COORD_BITS:1];
				semi_a_q   <= a_new;
				semi_b_q   <= b_new;
				color_q    <= s_tdata[4*CORNER_W+COLOR_W-1:4*CORNER_W];
				ofs_x_q    <= '0;
				ofs_y_q    <= OFS_W'(b_new);
				grad_x_q   <= '0;
			end
			OP_MUL_AA: begin
				prod_q <= mul_p[DEC_W-1:0];
			end
			OP_MUL_BB: begin
				sq_a_q <= prod_q[SQ_W-1:0];
				prod_q <= mul_p[DEC_W-1:0];
			end
			OP_MUL_AAB: begin
				sq_b_q <= prod_q[SQ_W-1:0];
				prod_q <= mul_p[DEC_W-1:0];
			end
			OP_INIT: begin
				grad_y_q <= {prod_q[GRAD_W-2:0], 1'b0};
				dec_q    <= quarter_trunc(init_sum);
			end
			OP_STEP: begin
				pt_rx_q <= PT_W'(center_x_q) + PT_W'(ofs_x_q);
				pt_lx_q <= PT_W'(center_x_q) - PT_W'(ofs_x_q);
				pt_ly_q <= PT_W'(center_y_q) + PT_W'(ofs_y_q);
				pt_uy_q <= PT_W'(center_y_q) - PT_W'(ofs_y_q);
				if (!cmd.region_two) begin
					ofs_x_q  <= ofs_x_q + OFS_W'(1);
					grad_x_q <= grad_x_q + two_sqb;
					br_q     <= !dec_neg;
					if (!dec_neg) begin
						ofs_y_q  <= ofs_y_q - OFS_W'(1);
						grad_y_q <= grad_y_q - two_sqa;
					end
				end else begin
					ofs_y_q  <= ofs_y_q - OFS_W'(1);
					grad_y_q <= grad_y_q - two_sqa;
					br_q     <= !dec_pos;
					if (!dec_pos) begin
						ofs_x_q  <= ofs_x_q + OFS_W'(1);
						grad_x_q <= grad_x_q + two_sqb;
					end
				end
			end
			OP_DECIDE: begin
				// The gradients already hold their values after the step.
				if (!cmd.region_two) begin
					if (br_q) begin
						dec_q <= dec_q + gx_w - gy_w + sqb_w;
					end else begin
						dec_q <= dec_q + gx_w + sqb_w;
					end
				end else begin
					if (br_q) begin
						dec_q <= dec_q + gx_w - gy_w + sqa_w;
					end else begin
						dec_q <= dec_q + sqa_w - gy_w;
					end
				end
			end
			OP_RC1, OP_RC2, OP_RC4: begin
				prod_q <= mul_p[DEC_W-1:0];
			end
			OP_RC3: begin
				acc_q  <= prod_q;
				prod_q <= mul_p[DEC_W-1:0];
			end
			OP_RC5: begin
				acc_q  <= acc_q + (prod_q <<< 2);
				prod_q <= mul_p[DEC_W-1:0];
			end
			OP_RC6: begin
				acc_q <= acc_q - (prod_q <<< 2);
			end
			OP_RC7: begin
				dec_q <= quarter_trunc(acc_q);
			end
			default: begin
			end
		endcase

		if (cmd.load_out) begin
			out_q <= {color_q, pt_uy_q, pt_ly_q, pt_lx_q, pt_rx_q};
		end
	end

	assign sts.gx_lt_gy = grad_x_q < grad_y_q;
	assign sts.oy_neg   = ofs_y_q[OFS_W-1];
	assign m_tdata      = out_q;

endmodule
`default_nettype wire

/* hdl/eor_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eor_ctrl: sequencer of the ellipse outline rasterizer
// Walks the start setup, the step and decision update, the region change
// and the hand-off to the output register; tracks the drawing phase.
// ----------------------------------------------------------------------------
module eor_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic               s_tuser,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic                    m_tlast,
	output eor_pkg::ctrl_cmd_t      cmd,
	input  wire eor_pkg::dp_sts_t   sts
);
	import eor_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SQ_A   = 4'd1;
	localparam logic [3:0] ST_SQ_B   = 4'd2;
	localparam logic [3:0] ST_AB     = 4'd3;
	localparam logic [3:0] ST_INIT   = 4'd4;
	localparam logic [3:0] ST_DECIDE = 4'd5;
	localparam logic [3:0] ST_CHECK  = 4'd6;
	localparam logic [3:0] ST_RC1    = 4'd7;
	localparam logic [3:0] ST_RC2    = 4'd8;
	localparam logic [3:0] ST_RC3    = 4'd9;
	localparam logic [3:0] ST_RC4    = 4'd10;
	localparam logic [3:0] ST_RC5    = 4'd11;
	localparam logic [3:0] ST_RC6    = 4'd12;
	localparam logic [3:0] ST_RC7    = 4'd13;
	localparam logic [3:0] ST_EMIT   = 4'd14;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ONE  = 2'd1;
	localparam logic [1:0] PH_TWO  = 2'd2;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d, phase_end;
	logic       adv_q, adv_d;
	logic       last_q, last_d;
	logic       m_tvalid_q, m_tlast_q;
	logic       accept;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign phase_end = (phase_q == PH_TWO && sts.oy_neg) ? PH_IDLE : phase_q;

	always_comb begin
		state_d        = state_q;
		phase_d        = phase_q;
		adv_d          = adv_q;
		last_d         = last_q;
		cmd.op         = OP_NONE;
		cmd.region_two = (phase_q == PH_TWO);
		cmd.load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == CMD_START) begin
						cmd.op  = OP_LOAD;
						adv_d   = 1'b0;
						state_d = ST_SQ_A;
					end else if (phase_q != PH_IDLE) begin
						// The step itself happens at the accepting edge.
						cmd.op  = OP_STEP;
						adv_d   = 1'b1;
						state_d = ST_DECIDE;
					end
				end
			end
			ST_SQ_A: begin
				cmd.op  = OP_MUL_AA;
				state_d = ST_SQ_B;
			end
			ST_SQ_B: begin
				cmd.op  = OP_MUL_BB;
				state_d = ST_AB;
			end
			ST_AB: begin
				cmd.op  = OP_MUL_AAB;
				state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.op  = OP_INIT;
				phase_d = PH_ONE;
				state_d = ST_CHECK;
			end
			ST_DECIDE: begin
				cmd.op  = OP_DECIDE;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (phase_q == PH_ONE && !sts.gx_lt_gy) begin
					state_d = ST_RC1;
				end else begin
					phase_d = phase_end;
					last_d  = (phase_end == PH_IDLE);
					state_d = adv_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_RC1: begin
				cmd.op  = OP_RC1;
				state_d = ST_RC2;
			end
			ST_RC2: begin
				cmd.op  = OP_RC2;
				state_d = ST_RC3;
			end
			ST_RC3: begin
				cmd.op  = OP_RC3;
				state_d = ST_RC4;
			end
			ST_RC4: begin
				cmd.op  = OP_RC4;
				state_d = ST_RC5;
			end
			ST_RC5: begin
				cmd.op  = OP_RC5;
				state_d = ST_RC6;
			end
			ST_RC6: begin
				cmd.op  = OP_RC6;
				state_d = ST_RC7;
			end
			ST_RC7: begin
				cmd.op  = OP_RC7;
				phase_d = PH_TWO;
				state_d = ST_CHECK;
			end
			ST_EMIT: begin
				// Wait here until the output register is free for the transfer.
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_IDLE;
			adv_q      <= 1'b0;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			adv_q   <= adv_d;
			last_q  <= last_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
				m_tlast_q  <= last_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire
